// ===== rtl/sparse_poly_term_merge_add_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sparse polynomial merge adder
// Shared wrappers that keep clocking and reset handling uniform.
// ---------------------------------------------------------------------------
`ifndef SPARSE_POLY_TERM_MERGE_ADD_ASSERT_SVH
`define SPARSE_POLY_TERM_MERGE_ADD_ASSERT_SVH

// Checked at every rising edge, disabled while reset is asserted.
`define SPMA_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, including reset cycles.
`define SPMA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spma_pkg.sv =====
// ---------------------------------------------------------------------------
// Sparse polynomial merge adder package
// Shared types, opcodes, state encoding and defaults.
// ---------------------------------------------------------------------------
package spma_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int COEF_W        = 32;
    localparam int EXP_W         = 16;
    localparam int SUM_W         = COEF_W + 1;

    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_MERGE       = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [COEF_W-1:0] term_coefficient;
        logic [EXP_W-1:0]         term_exponent;
    } spma_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_coefficient;
        logic [EXP_W-1:0]        sum_exponent;
        logic                    last_term;
        logic                    terms_dropped;
    } spma_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [EXP_W-1:0]         exponent;
    } spma_term_t;

    typedef enum logic {
        SPMA_IDLE,
        SPMA_MERGE
    } spma_state_t;

endpackage

// ===== rtl/sparse_poly_term_merge_add.sv =====
// ---------------------------------------------------------------------------
// Sparse polynomial merge adder
// Loads two term lists and merges them into one sum polynomial.
// ---------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_data) takes one command per
// transaction. A load command appends a term to the first or second list;
// a load into a full list is dropped and flagged on the next merge. A
// merge command starts the merge engine, which walks both list memories
// with two read pointers and, while the output register can take it,
// writes one result term per cycle into the output register on the result
// channel (m_valid, m_ready, m_data). The first term reaches the result
// channel through the state register and the output register; it can be
// held back by a stalled last term of the previous merge. The list
// memories have registered read data and there is a single merge unit.
// s_ready is low while a merge runs.
// If the receiver stalls, the output register holds its term and the
// engine waits. Reset empties both lists, clears the dropped flag and
// the output valid flag; the list memories themselves are not cleared.
// ---------------------------------------------------------------------------
module sparse_poly_term_merge_add #(
    parameter int MAX_TERMS = spma_pkg::MAX_TERMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spma_pkg::spma_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output spma_pkg::spma_out_t m_data
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    spma_pkg::spma_state_t state_reg;
    spma_pkg::spma_state_t state_next;
    logic [CW-1:0]         cnt_a_reg;
    logic [CW-1:0]         cnt_a_next;
    logic [CW-1:0]         cnt_b_reg;
    logic [CW-1:0]         cnt_b_next;
    logic [CW-1:0]         ptr_a_reg;
    logic [CW-1:0]         ptr_a_next;
    logic [CW-1:0]         ptr_b_reg;
    logic [CW-1:0]         ptr_b_next;
    logic                  dropped_reg;
    logic                  dropped_next;

    logic                  accept;
    logic                  is_load_a;
    logic                  is_load_b;
    logic                  is_merge;
    logic                  wr_a;
    logic                  wr_b;
    spma_pkg::spma_term_t  wr_term;
    spma_pkg::spma_term_t  rd_a;
    spma_pkg::spma_term_t  rd_b;

    logic                  a_avail;
    logic                  b_avail;
    logic                  take_a;
    logic                  take_b;
    logic [CW-1:0]         ptr_a_adv;
    logic [CW-1:0]         ptr_b_adv;
    logic                  last;
    logic                  emit;
    logic                  o_ready;
    logic                  merging;
    spma_pkg::spma_out_t   o_data;

    assign accept    = s_valid && s_ready;
    assign is_load_a = accept && (s_data.opcode == spma_pkg::OP_LOAD_FIRST);
    assign is_load_b = accept && (s_data.opcode == spma_pkg::OP_LOAD_SECOND);
    assign is_merge  = accept && (s_data.opcode == spma_pkg::OP_MERGE);
    assign wr_a      = is_load_a && (cnt_a_reg < CW'(MAX_TERMS));
    assign wr_b      = is_load_b && (cnt_b_reg < CW'(MAX_TERMS));

    assign wr_term.coefficient = s_data.term_coefficient;
    assign wr_term.exponent    = s_data.term_exponent;

    spma_term_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_mem_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[AW-1:0]),
        .wr_data (wr_term),
        .rd_addr (ptr_a_next[AW-1:0]),
        .rd_data (rd_a)
    );

    spma_term_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_mem_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[AW-1:0]),
        .wr_data (wr_term),
        .rd_addr (ptr_b_next[AW-1:0]),
        .rd_data (rd_b)
    );

    assign a_avail = ptr_a_reg < cnt_a_reg;
    assign b_avail = ptr_b_reg < cnt_b_reg;

    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (a_avail && b_avail) begin
            if (rd_a.exponent == rd_b.exponent) begin
                take_a = 1'b1;
                take_b = 1'b1;
            end else if (rd_a.exponent > rd_b.exponent) begin
                take_a = 1'b1;
            end else begin
                take_b = 1'b1;
            end
        end else if (a_avail) begin
            take_a = 1'b1;
        end else begin
            take_b = 1'b1;
        end
    end

    assign ptr_a_adv = ptr_a_reg + CW'(take_a);
    assign ptr_b_adv = ptr_b_reg + CW'(take_b);
    assign last      = (ptr_a_adv >= cnt_a_reg) && (ptr_b_adv >= cnt_b_reg);

    always_comb begin
        logic signed [spma_pkg::SUM_W-1:0] ext_a;
        logic signed [spma_pkg::SUM_W-1:0] ext_b;
        ext_a = {rd_a.coefficient[spma_pkg::COEF_W-1], rd_a.coefficient};
        ext_b = {rd_b.coefficient[spma_pkg::COEF_W-1], rd_b.coefficient};
        if (take_a && take_b) begin
            o_data.sum_coefficient = ext_a + ext_b;
        end else if (take_a) begin
            o_data.sum_coefficient = ext_a;
        end else begin
            o_data.sum_coefficient = ext_b;
        end
        o_data.sum_exponent  = take_a ? rd_a.exponent : rd_b.exponent;
        o_data.last_term     = last;
        o_data.terms_dropped = dropped_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spma_pkg::SPMA_IDLE: begin
                if (is_merge && ((cnt_a_reg != '0) || (cnt_b_reg != '0))) begin
                    state_next = spma_pkg::SPMA_MERGE;
                end
            end
            spma_pkg::SPMA_MERGE: begin
                if (o_ready && last) begin
                    state_next = spma_pkg::SPMA_IDLE;
                end
            end
            default: begin
                state_next = spma_pkg::SPMA_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        merging = 1'b0;
        case (state_reg)
            spma_pkg::SPMA_IDLE: begin
                s_ready = 1'b1;
            end
            spma_pkg::SPMA_MERGE: begin
                merging = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign emit = merging && o_ready;

    always_comb begin
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        ptr_a_next   = ptr_a_reg;
        ptr_b_next   = ptr_b_reg;
        dropped_next = dropped_reg;
        if (wr_a) begin
            cnt_a_next = cnt_a_reg + CW'(1);
        end
        if (wr_b) begin
            cnt_b_next = cnt_b_reg + CW'(1);
        end
        if ((is_load_a && !wr_a) || (is_load_b && !wr_b)) begin
            dropped_next = 1'b1;
        end
        if (emit) begin
            if (last) begin
                cnt_a_next   = '0;
                cnt_b_next   = '0;
                ptr_a_next   = '0;
                ptr_b_next   = '0;
                dropped_next = 1'b0;
            end else begin
                ptr_a_next = ptr_a_adv;
                ptr_b_next = ptr_b_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spma_pkg::SPMA_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            ptr_a_reg   <= '0;
            ptr_b_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            ptr_a_reg   <= ptr_a_next;
            ptr_b_reg   <= ptr_b_next;
            dropped_reg <= dropped_next;
        end
    end

    spma_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (merging),
        .in_ready (o_ready),
        .in_data  (o_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== rtl/spma_term_mem.sv =====
// ---------------------------------------------------------------------------
// Term list memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module spma_term_mem #(
    parameter int DEPTH = spma_pkg::MAX_TERMS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  spma_pkg::spma_term_t wr_data,
    input  logic [AW-1:0]       rd_addr,
    output spma_pkg::spma_term_t rd_data
);

    spma_pkg::spma_term_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/spma_out_reg.sv =====
// ---------------------------------------------------------------------------
// Result output register
// Holds one result transaction so the merge engine can run ahead of a
// stalled receiver by one term.
// ---------------------------------------------------------------------------
module spma_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  spma_pkg::spma_out_t in_data,
    output logic                m_valid,
    input  logic                m_ready,
    output spma_pkg::spma_out_t m_data
);

    logic                valid_reg;
    logic                valid_next;
    spma_pkg::spma_out_t data_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/spma_checker.sv =====
// ---------------------------------------------------------------------------
// Sparse polynomial merge adder port checker
// Watches the top-level ports and is attached by a bind statement.
// ---------------------------------------------------------------------------
`include "sparse_poly_term_merge_add_assert.svh"

module spma_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input spma_pkg::spma_out_t m_data
);

    `SPMA_ASSERT_ALWAYS(a_reset_clears_out, aclk,
        !aresetn |=> !m_valid, "result valid after reset")
    `SPMA_ASSERT_RST(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_data),
        "stalled result transaction changed")
    `SPMA_ASSERT_RST(a_merge_continues, aclk, aresetn,
        m_valid && m_ready && !m_data.last_term |=> m_valid
            && (m_data.terms_dropped == $past(m_data.terms_dropped)),
        "merge stream broken or dropped flag changed")
    `SPMA_ASSERT_RST(a_busy_while_streaming, aclk, aresetn,
        m_valid && !m_data.last_term |-> !s_ready, "input accepted during a merge")

endmodule

bind sparse_poly_term_merge_add spma_checker u_spma_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
